[src/ipdfd_pkg.sv]
`timescale 1ns / 1ps

package ipdfd_pkg;

   // Default sizing of the header parser.
   localparam int LINE_CAPACITY = 48;
   localparam int LENGTH_BITS   = 16;

   // Characters the parser reacts to.
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Both close markers are six characters long.
   localparam logic [2:0] MARK_LEN = 3'd6;

   typedef enum logic {
      MARK_CLOSED,
      MARK_UNLINK
   } mark_sel_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_LINE = 2'd1,
      MODE_DATA = 2'd2
   } mode_type;

   // One parsed byte as it leaves the parser.
   typedef struct packed {
      logic       emit;
      logic [7:0] data;
      logic       from_payload;
      logic       link_closed;
   } result_type;

   // Character at a position of one of the close markers.
   function automatic logic [7:0] mark_char(mark_sel_type sel, logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      if (sel == MARK_CLOSED) begin
         case (pos)
            3'd0:    c = 8'h43; // C
            3'd1:    c = 8'h4C; // L
            3'd2:    c = 8'h4F; // O
            3'd3:    c = 8'h53; // S
            3'd4:    c = 8'h45; // E
            3'd5:    c = 8'h44; // D
            default: c = 8'h00;
         endcase
      end else begin
         case (pos)
            3'd0:    c = 8'h55; // U
            3'd1:    c = 8'h6E; // n
            3'd2:    c = 8'h6C; // l
            3'd3:    c = 8'h69; // i
            3'd4:    c = 8'h6E; // n
            3'd5:    c = 8'h6B; // k
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

endpackage

[src/ipdfd_req_if.sv]
`timescale 1ns / 1ps

interface ipdfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/ipdfd_rsp_if.sv]
`timescale 1ns / 1ps

interface ipdfd_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_valid;
   logic [7:0] out_byte;
   logic       from_payload;
   logic       link_closed;

   modport source (output valid, output out_valid, output out_byte,
                   output from_payload, output link_closed, input ready);
   modport sink   (input valid, input out_valid, input out_byte,
                   input from_payload, input link_closed, output ready);
endinterface

[src/ipdfd_parser.sv]
`timescale 1ns / 1ps

module ipdfd_parser #(
   parameter int LINE_CAPACITY = ipdfd_pkg::LINE_CAPACITY,
   parameter int LENGTH_BITS   = ipdfd_pkg::LENGTH_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   output ipdfd_pkg::result_type  result
);

   localparam int LC_W = $clog2(LINE_CAPACITY);
   localparam int AX_W = LENGTH_BITS + 4;
   localparam logic [LC_W-1:0]        LINE_LAST  = LC_W'(LINE_CAPACITY - 1);
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [2:0]             MARK_LEN_L = ipdfd_pkg::MARK_LEN;

   ipdfd_pkg::mode_type      mode_ff, mode_in;
   logic [LENGTH_BITS-1:0]   left_ff, left_in;
   logic [LC_W-1:0]          cnt_ff, cnt_in;
   logic                     comma_ff, comma_in;
   logic                     digits_ff, digits_in;
   logic [LENGTH_BITS-1:0]   accum_ff, accum_in;
   logic [2:0]               cpos_ff, cpos_in;
   logic [2:0]               upos_ff, upos_in;
   logic                     marker_ff, marker_in;
   logic                     closed_ff, closed_in;

   // Streaming marker match for the byte at hand.
   logic [2:0]      c_nx, u_nx;
   logic            c_done, u_done;
   logic            is_digit;
   logic [AX_W-1:0] acc_x, acc_v;

   always_comb begin
      if (cpos_ff < MARK_LEN_L && rx_byte == ipdfd_pkg::mark_char(ipdfd_pkg::MARK_CLOSED,
                                                                 cpos_ff)) begin
         c_nx = cpos_ff + 3'd1;
      end else begin
         c_nx = {2'b00, rx_byte == ipdfd_pkg::mark_char(ipdfd_pkg::MARK_CLOSED, 3'd0)};
      end
      if (upos_ff < MARK_LEN_L && rx_byte == ipdfd_pkg::mark_char(ipdfd_pkg::MARK_UNLINK,
                                                                 upos_ff)) begin
         u_nx = upos_ff + 3'd1;
      end else begin
         u_nx = {2'b00, rx_byte == ipdfd_pkg::mark_char(ipdfd_pkg::MARK_UNLINK, 3'd0)};
      end
      c_done   = (c_nx == MARK_LEN_L);
      u_done   = (u_nx == MARK_LEN_L);
      is_digit = (rx_byte >= ipdfd_pkg::CHAR_ZERO) && (rx_byte <= ipdfd_pkg::CHAR_NINE);
      // Length times ten plus the digit, by shift and add.
      acc_x    = AX_W'(accum_ff);
      acc_v    = (acc_x << 3) + (acc_x << 1) + AX_W'(rx_byte[3:0]);
   end

   always_comb begin
      mode_in   = mode_ff;
      left_in   = left_ff;
      cnt_in    = cnt_ff;
      comma_in  = comma_ff;
      digits_in = digits_ff;
      accum_in  = accum_ff;
      cpos_in   = cpos_ff;
      upos_in   = upos_ff;
      marker_in = marker_ff;
      closed_in = closed_ff;
      result    = '0;
      result.data        = rx_byte;
      result.link_closed = closed_ff;

      case (mode_ff)
         ipdfd_pkg::MODE_LINE: begin
            if (cnt_ff < LINE_LAST) begin
               cnt_in    = cnt_ff + LC_W'(1);
               cpos_in   = c_done ? 3'd0 : c_nx;
               upos_in   = u_done ? 3'd0 : u_nx;
               marker_in = marker_ff | c_done | u_done;
               if (!comma_ff) begin
                  if (rx_byte == ipdfd_pkg::CHAR_COMMA) begin
                     comma_in  = 1'b1;
                     digits_in = 1'b1;
                  end
               end else if (digits_ff) begin
                  if (is_digit) begin
                     accum_in = (acc_v > AX_W'(LENGTH_MAX)) ? LENGTH_MAX
                                                            : acc_v[LENGTH_BITS-1:0];
                  end else begin
                     digits_in = 1'b0;
                  end
               end
            end
            if (rx_byte == ipdfd_pkg::CHAR_LF) begin
               if (marker_in) begin
                  closed_in = 1'b1;
               end
               mode_in = ipdfd_pkg::MODE_IDLE;
            end else if (rx_byte == ipdfd_pkg::CHAR_COLON) begin
               left_in = comma_in ? accum_in : '0;
               mode_in = ipdfd_pkg::MODE_DATA;
            end
            if (rx_byte == ipdfd_pkg::CHAR_LF || rx_byte == ipdfd_pkg::CHAR_COLON) begin
               cnt_in    = '0;
               comma_in  = 1'b0;
               digits_in = 1'b0;
               accum_in  = '0;
               cpos_in   = 3'd0;
               upos_in   = 3'd0;
               marker_in = 1'b0;
            end
         end
         ipdfd_pkg::MODE_DATA: begin
            if (left_ff != '0) begin
               result.emit         = 1'b1;
               result.from_payload = 1'b1;
               left_in             = left_ff - LENGTH_BITS'(1);
               if (left_ff == LENGTH_BITS'(1)) begin
                  mode_in = ipdfd_pkg::MODE_IDLE;
               end
            end else begin
               // A zero length swallows this byte.
               mode_in = ipdfd_pkg::MODE_IDLE;
            end
         end
         default: begin
            if (rx_byte == ipdfd_pkg::CHAR_PLUS) begin
               cnt_in    = LC_W'(1);
               comma_in  = 1'b0;
               digits_in = 1'b0;
               accum_in  = '0;
               cpos_in   = 3'd0;
               upos_in   = 3'd0;
               marker_in = 1'b0;
               mode_in   = ipdfd_pkg::MODE_LINE;
            end else if (rx_byte == ipdfd_pkg::CHAR_CR || rx_byte == ipdfd_pkg::CHAR_LF) begin
               mode_in = ipdfd_pkg::MODE_IDLE;
            end else begin
               result.emit = 1'b1;
               mode_in     = ipdfd_pkg::MODE_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ipdfd_pkg::MODE_IDLE;
         left_ff   <= '0;
         cnt_ff    <= '0;
         comma_ff  <= 1'b0;
         digits_ff <= 1'b0;
         accum_ff  <= '0;
         cpos_ff   <= 3'd0;
         upos_ff   <= 3'd0;
         marker_ff <= 1'b0;
         closed_ff <= 1'b0;
      end else if (step) begin
         mode_ff   <= mode_in;
         left_ff   <= left_in;
         cnt_ff    <= cnt_in;
         comma_ff  <= comma_in;
         digits_ff <= digits_in;
         accum_ff  <= accum_in;
         cpos_ff   <= cpos_in;
         upos_ff   <= upos_in;
         marker_ff <= marker_in;
         closed_ff <= closed_in;
      end
   end

endmodule

[src/ipd_frame_deframer_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Interface      Contents
// req_if    in         ipdfd_req_if   rx_byte, one received modem byte per transaction
// rsp_if    out        ipdfd_rsp_if   out_valid, out_byte, from_payload, link_closed
//
// Every accepted byte is registered in the input register, parsed from there and, if it
// yields a data byte, placed in the result register.
// A byte can be accepted in every cycle; the only limit is the result register.
// Reset is synchronous and returns the parser to idle with the closed flag clear.
// While a result waits for rsp_if.ready, one more byte is held in the input
// register and req_if.ready drops only when both registers are full.

module ipd_frame_deframer_top #(
   parameter int LINE_CAPACITY = ipdfd_pkg::LINE_CAPACITY,
   parameter int LENGTH_BITS   = ipdfd_pkg::LENGTH_BITS
) (
   input  logic        clock,
   input  logic        reset,
   ipdfd_req_if.sink   req_if,
   ipdfd_rsp_if.source rsp_if
);

   // Input register: holds the byte being parsed.
   logic       s1_v_ff, s1_v_in;
   logic [7:0] s1_byte_ff;

   // Result register.
   logic       out_v_ff, out_v_in;
   logic [7:0] out_byte_ff;
   logic       out_pay_ff;
   logic       out_closed_ff;

   ipdfd_pkg::result_type result;

   // The parsed byte moves on when the result register is free or being emptied.
   // Parser state advances only then, so each byte is parsed exactly once.
   logic advance;
   assign advance      = s1_v_ff && (!out_v_ff || rsp_if.ready);
   assign req_if.ready = !s1_v_ff || advance;

   ipdfd_parser #(
      .LINE_CAPACITY (LINE_CAPACITY),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (s1_byte_ff),
      .result  (result)
   );

   always_comb begin
      s1_v_in = s1_v_ff;
      if (req_if.valid && req_if.ready) begin
         s1_v_in = 1'b1;
      end else if (advance) begin
         s1_v_in = 1'b0;
      end

      out_v_in = out_v_ff;
      if (advance) begin
         out_v_in = result.emit;
      end else if (rsp_if.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_byte_ff <= req_if.rx_byte;
      end
      if (advance && result.emit) begin
         out_byte_ff   <= result.data;
         out_pay_ff    <= result.from_payload;
         out_closed_ff <= result.link_closed;
      end
   end

   assign rsp_if.valid        = out_v_ff;
   assign rsp_if.out_valid    = out_v_ff;
   assign rsp_if.out_byte     = out_v_ff ? out_byte_ff : 8'h00;
   assign rsp_if.from_payload = out_v_ff && out_pay_ff;
   assign rsp_if.link_closed  = out_v_ff && out_closed_ff;

   // Input stalls only when both the input and result registers are occupied.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (s1_v_ff && out_v_ff && !rsp_if.ready))
      else $error("input stalled without a full pipeline");

   // A parked byte stays put until it can advance.
   a_hold_parked: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !advance) |=> (s1_v_ff && $stable(s1_byte_ff)))
      else $error("parked byte lost or changed");

   // A taken result with nothing behind it leaves the result register empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rsp_if.ready && !advance) |=> !out_v_ff)
      else $error("result repeated after it was taken");

endmodule
